// ===== rtl/core/tpcm_pkg.sv =====
package tpcm_pkg;

   localparam int unsigned SCREEN_WIDTH    = 320;
   localparam int unsigned SCREEN_HEIGHT   = 240;
   localparam int unsigned SCALE_FRAC_BITS = 16;
   localparam int unsigned MARGIN          = 10;

   localparam int unsigned RAW_W   = 12;
   localparam int unsigned SIZE_W  = 13;
   localparam int unsigned SCALE_W = 20;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned HOLD_W  = 16;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned TGTX_W  = 9;
   localparam int unsigned TGTY_W  = 8;
   localparam int unsigned RES_W   = 16;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned DATA_W  = 32;

   localparam int unsigned PROD_W  = RAW_W + SCALE_W;
   localparam int unsigned MAP_W   = PROD_W + 2;
   localparam int unsigned CNT_W   = $clog2(SCALE_W);
   localparam int unsigned CMP_W   = (SIZE_W + SCALE_FRAC_BITS > RAW_W + SCALE_W) ?
                                     SIZE_W + SCALE_FRAC_BITS : RAW_W + SCALE_W;

   localparam logic [SCALE_W-1:0] SCALE_MAX   = '1;
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1 << SCALE_FRAC_BITS);
   localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(1000);

   localparam logic [SIZE_W-1:0] SIZE_X = SIZE_W'(SCREEN_WIDTH);
   localparam logic [SIZE_W-1:0] SIZE_Y = SIZE_W'(SCREEN_HEIGHT);

   localparam logic [TGTX_W-1:0] TARGET_X0 = TGTX_W'(MARGIN);
   localparam logic [TGTY_W-1:0] TARGET_Y0 = TGTY_W'(MARGIN);
   localparam logic [TGTX_W-1:0] TARGET_X1 = TGTX_W'(SCREEN_WIDTH - MARGIN);
   localparam logic [TGTY_W-1:0] TARGET_Y1 = TGTY_W'(SCREEN_HEIGHT - MARGIN);

   localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_DONE   = 2'd2;

   localparam logic [IDX_W-1:0] REG_PRESET_SCALE_X  = 3'd0;
   localparam logic [IDX_W-1:0] REG_PRESET_SCALE_Y  = 3'd1;
   localparam logic [IDX_W-1:0] REG_PRESET_OFFSET_X = 3'd2;
   localparam logic [IDX_W-1:0] REG_PRESET_OFFSET_Y = 3'd3;
   localparam logic [IDX_W-1:0] REG_PRESET_VALID    = 3'd4;
   localparam logic [IDX_W-1:0] REG_HOLD_MS         = 3'd5;

   localparam logic signed [MAP_W-1:0] RES_MAX = MAP_W'((1 << (RES_W - 1)) - 1);
   localparam logic signed [MAP_W-1:0] RES_MIN = -RES_MAX - MAP_W'(1);

endpackage

// ===== rtl/core/tpcm_div.sv =====
module tpcm_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tpcm_pkg::SIZE_W-1:0]       size,
   input  logic [tpcm_pkg::RAW_W-1:0]        a,
   input  logic [tpcm_pkg::RAW_W-1:0]        b,
   output logic                              done,
   output logic [tpcm_pkg::SCALE_W-1:0]      scale,
   output logic [tpcm_pkg::RAW_W-1:0]        low
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [tpcm_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [tpcm_pkg::RAW_W-1:0]         rem_ff, rem_in;
   logic [tpcm_pkg::SCALE_W-1:0]       quot_ff, quot_in;
   logic [tpcm_pkg::RAW_W-1:0]         diff_ff, diff_in;
   logic [tpcm_pkg::RAW_W-1:0]         low_ff, low_in;
   logic [tpcm_pkg::CMP_W-1:0]         num;
   logic                               sat;
   logic [tpcm_pkg::RAW_W:0]           trial;
   logic                               ge;

   always_comb begin
      num     = tpcm_pkg::CMP_W'(size) << tpcm_pkg::SCALE_FRAC_BITS;
      diff_in = diff_ff;
      low_in  = low_ff;
      if (start) begin
         diff_in = (a > b) ? a - b : b - a;
         low_in  = (a < b) ? a : b;
      end
      sat   = num >= (tpcm_pkg::CMP_W'(diff_in) << tpcm_pkg::SCALE_W);
      trial = {rem_ff, quot_ff[tpcm_pkg::SCALE_W-1]};
      ge    = trial >= {1'b0, diff_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = !sat;
         done_in = sat;
         cnt_in  = '0;
         rem_in  = tpcm_pkg::RAW_W'(num >> tpcm_pkg::SCALE_W);
         quot_in = sat ? tpcm_pkg::SCALE_MAX : num[tpcm_pkg::SCALE_W-1:0];
      end else if (busy_ff) begin
         rem_in  = ge ? tpcm_pkg::RAW_W'(trial - {1'b0, diff_ff}) : trial[tpcm_pkg::RAW_W-1:0];
         quot_in = {quot_ff[tpcm_pkg::SCALE_W-2:0], ge};
         cnt_in  = cnt_ff + tpcm_pkg::CNT_W'(1);
         if (cnt_ff == tpcm_pkg::CNT_W'(tpcm_pkg::SCALE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      diff_ff <= diff_in;
      low_ff  <= low_in;
   end

   assign done  = done_ff;
   assign scale = quot_ff;
   assign low   = low_ff;

endmodule

// ===== rtl/core/touch_two_point_calibrate_map.sv =====
// A word is accepted only while the sequencer is idle; csr writes are taken every cycle.
// Uncalibrated words go straight to loading the output; mapped words pass, per axis,
// through the shared multiplier and the saturating subtract before the output is loaded.
// A new word waits until the result is loaded, which may stall on rsp_ready. The word
// that completes calibration adds two divisions of up to 20 steps on the shared divider.
// Synchronous reset clears calibration to phase 0, scales to 1.0, offsets, preset_valid.
module touch_two_point_calibrate_map (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tpcm_pkg::RAW_W-1:0]         req_raw_x,
   input  logic [tpcm_pkg::RAW_W-1:0]         req_raw_y,
   input  logic                               req_pen_down,
   input  logic [tpcm_pkg::TIME_W-1:0]        req_now_ms,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tpcm_pkg::PHASE_W-1:0]       rsp_phase,
   output logic [tpcm_pkg::TGTX_W-1:0]        rsp_target_x,
   output logic [tpcm_pkg::TGTY_W-1:0]        rsp_target_y,
   output logic                               rsp_point_valid,
   output logic signed [tpcm_pkg::RES_W-1:0]  rsp_screen_x,
   output logic signed [tpcm_pkg::RES_W-1:0]  rsp_screen_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tpcm_pkg::IDX_W-1:0]         csr_index,
   input  logic [tpcm_pkg::DATA_W-1:0]        csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIVS  = 3'd1;
   localparam logic [2:0] ST_DIVW  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_MAP   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                          state_ff, state_in;
   logic                                axis_ff, axis_in;
   logic [tpcm_pkg::PHASE_W-1:0]        cal_phase_ff, cal_phase_in;
   logic [tpcm_pkg::RAW_W-1:0]          first_x_ff, first_x_in;
   logic [tpcm_pkg::RAW_W-1:0]          first_y_ff, first_y_in;
   logic [tpcm_pkg::TIME_W-1:0]         last_change_ms_ff, last_change_ms_in;
   logic [tpcm_pkg::SCALE_W-1:0]        scale_x_ff, scale_x_in;
   logic [tpcm_pkg::SCALE_W-1:0]        scale_y_ff, scale_y_in;
   logic [tpcm_pkg::RAW_W-1:0]          offset_x_ff, offset_x_in;
   logic [tpcm_pkg::RAW_W-1:0]          offset_y_ff, offset_y_in;
   logic [tpcm_pkg::SCALE_W-1:0]        preset_scale_x_ff, preset_scale_x_in;
   logic [tpcm_pkg::SCALE_W-1:0]        preset_scale_y_ff, preset_scale_y_in;
   logic [tpcm_pkg::RAW_W-1:0]          preset_offset_x_ff, preset_offset_x_in;
   logic [tpcm_pkg::RAW_W-1:0]          preset_offset_y_ff, preset_offset_y_in;
   logic                                preset_valid_ff, preset_valid_in;
   logic [tpcm_pkg::HOLD_W-1:0]         hold_ms_ff, hold_ms_in;
   logic [tpcm_pkg::RAW_W-1:0]          raw_x_ff, raw_x_in;
   logic [tpcm_pkg::RAW_W-1:0]          raw_y_ff, raw_y_in;
   logic [tpcm_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic                                neg_ff, neg_in;
   logic signed [tpcm_pkg::RES_W-1:0]   screen_x_ff, screen_x_in;
   logic signed [tpcm_pkg::RES_W-1:0]   screen_y_ff, screen_y_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tpcm_pkg::PHASE_W-1:0]        rsp_phase_ff, rsp_phase_in;
   logic [tpcm_pkg::TGTX_W-1:0]         rsp_target_x_ff, rsp_target_x_in;
   logic [tpcm_pkg::TGTY_W-1:0]         rsp_target_y_ff, rsp_target_y_in;
   logic signed [tpcm_pkg::RES_W-1:0]   rsp_screen_x_ff, rsp_screen_x_in;
   logic signed [tpcm_pkg::RES_W-1:0]   rsp_screen_y_ff, rsp_screen_y_in;

   logic                                accept;
   logic [tpcm_pkg::TIME_W-1:0]         elapsed;
   logic                                div_start;
   logic                                div_done;
   logic [tpcm_pkg::SIZE_W-1:0]         div_size;
   logic [tpcm_pkg::RAW_W-1:0]          div_a;
   logic [tpcm_pkg::RAW_W-1:0]          div_b;
   logic [tpcm_pkg::SCALE_W-1:0]        div_scale;
   logic [tpcm_pkg::RAW_W-1:0]          div_low;
   logic [tpcm_pkg::RAW_W-1:0]          map_raw;
   logic [tpcm_pkg::RAW_W-1:0]          map_off;
   logic [tpcm_pkg::SCALE_W-1:0]        map_scale;
   logic [tpcm_pkg::SIZE_W-1:0]         map_size;
   logic [tpcm_pkg::RAW_W:0]            map_diff;
   logic [tpcm_pkg::RAW_W-1:0]          map_mag;
   logic signed [tpcm_pkg::MAP_W-1:0]   map_t;
   logic signed [tpcm_pkg::MAP_W-1:0]   map_r;
   logic signed [tpcm_pkg::RES_W-1:0]   map_sat;
   logic [tpcm_pkg::PHASE_W-1:0]        phase_rep;
   logic                                out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign elapsed   = req_now_ms - last_change_ms_ff;
   assign phase_rep = preset_valid_ff ? tpcm_pkg::PHASE_DONE : cal_phase_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_start = (state_ff == ST_DIVS);

   // The pairing is crossed: the x scale and offset come from the raw y readings.
   assign div_size = axis_ff ? tpcm_pkg::SIZE_Y : tpcm_pkg::SIZE_X;
   assign div_a    = axis_ff ? first_x_ff : first_y_ff;
   assign div_b    = axis_ff ? raw_x_ff : raw_y_ff;

   tpcm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .size  (div_size),
      .a     (div_a),
      .b     (div_b),
      .done  (div_done),
      .scale (div_scale),
      .low   (div_low)
   );

   always_comb begin
      map_raw   = axis_ff ? raw_y_ff : raw_x_ff;
      map_size  = axis_ff ? tpcm_pkg::SIZE_Y : tpcm_pkg::SIZE_X;
      if (preset_valid_ff) begin
         map_off   = axis_ff ? preset_offset_y_ff : preset_offset_x_ff;
         map_scale = axis_ff ? preset_scale_y_ff : preset_scale_x_ff;
      end else begin
         map_off   = axis_ff ? offset_y_ff : offset_x_ff;
         map_scale = axis_ff ? scale_y_ff : scale_x_ff;
      end
      map_diff = {1'b0, map_raw} - {1'b0, map_off};
      map_mag  = map_diff[tpcm_pkg::RAW_W] ? tpcm_pkg::RAW_W'(-map_diff)
                                           : map_diff[tpcm_pkg::RAW_W-1:0];
      map_t    = $signed(tpcm_pkg::MAP_W'(prod_ff >> tpcm_pkg::SCALE_FRAC_BITS));
      map_r    = neg_ff ? $signed(tpcm_pkg::MAP_W'(map_size)) + map_t
                        : $signed(tpcm_pkg::MAP_W'(map_size)) - map_t;
      if (map_r > tpcm_pkg::RES_MAX) begin
         map_sat = tpcm_pkg::RES_W'(tpcm_pkg::RES_MAX);
      end else if (map_r < tpcm_pkg::RES_MIN) begin
         map_sat = tpcm_pkg::RES_W'(tpcm_pkg::RES_MIN);
      end else begin
         map_sat = map_r[tpcm_pkg::RES_W-1:0];
      end
   end

   always_comb begin
      preset_scale_x_in  = preset_scale_x_ff;
      preset_scale_y_in  = preset_scale_y_ff;
      preset_offset_x_in = preset_offset_x_ff;
      preset_offset_y_in = preset_offset_y_ff;
      preset_valid_in    = preset_valid_ff;
      hold_ms_in         = hold_ms_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tpcm_pkg::REG_PRESET_SCALE_X: begin
               preset_scale_x_in = csr_wdata[tpcm_pkg::SCALE_W-1:0];
            end
            tpcm_pkg::REG_PRESET_SCALE_Y: begin
               preset_scale_y_in = csr_wdata[tpcm_pkg::SCALE_W-1:0];
            end
            tpcm_pkg::REG_PRESET_OFFSET_X: begin
               preset_offset_x_in = csr_wdata[tpcm_pkg::RAW_W-1:0];
            end
            tpcm_pkg::REG_PRESET_OFFSET_Y: begin
               preset_offset_y_in = csr_wdata[tpcm_pkg::RAW_W-1:0];
            end
            tpcm_pkg::REG_PRESET_VALID: begin
               preset_valid_in = csr_wdata[0];
            end
            tpcm_pkg::REG_HOLD_MS: begin
               hold_ms_in = csr_wdata[tpcm_pkg::HOLD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in          = state_ff;
      axis_in           = axis_ff;
      cal_phase_in      = cal_phase_ff;
      first_x_in        = first_x_ff;
      first_y_in        = first_y_ff;
      last_change_ms_in = last_change_ms_ff;
      scale_x_in        = scale_x_ff;
      scale_y_in        = scale_y_ff;
      offset_x_in       = offset_x_ff;
      offset_y_in       = offset_y_ff;
      raw_x_in          = raw_x_ff;
      raw_y_in          = raw_y_ff;
      prod_in           = prod_ff;
      neg_in            = neg_ff;
      screen_x_in       = screen_x_ff;
      screen_y_in       = screen_y_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_phase_in      = rsp_phase_ff;
      rsp_target_x_in   = rsp_target_x_ff;
      rsp_target_y_in   = rsp_target_y_ff;
      rsp_screen_x_in   = rsp_screen_x_ff;
      rsp_screen_y_in   = rsp_screen_y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               raw_x_in = req_raw_x;
               raw_y_in = req_raw_y;
               axis_in  = 1'b0;
               state_in = preset_valid_ff ? ST_MUL : ST_DONE;
               if (req_restart) begin
                  cal_phase_in = tpcm_pkg::PHASE_FIRST;
                  state_in     = preset_valid_ff ? ST_MUL : ST_DONE;
               end else if (!preset_valid_ff) begin
                  if (cal_phase_ff == tpcm_pkg::PHASE_FIRST) begin
                     if (req_pen_down) begin
                        first_x_in        = req_raw_x;
                        first_y_in        = req_raw_y;
                        last_change_ms_in = req_now_ms;
                        cal_phase_in      = tpcm_pkg::PHASE_SECOND;
                     end
                  end else if (cal_phase_ff == tpcm_pkg::PHASE_SECOND) begin
                     if (req_pen_down && elapsed > tpcm_pkg::TIME_W'(hold_ms_ff)) begin
                        last_change_ms_in = req_now_ms;
                        cal_phase_in      = tpcm_pkg::PHASE_DONE;
                        state_in          = ST_DIVS;
                     end
                  end else begin
                     state_in = ST_MUL;
                  end
               end
            end
         end
         ST_DIVS: begin
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               if (axis_ff) begin
                  scale_y_in  = div_scale;
                  offset_y_in = div_low;
                  axis_in     = 1'b0;
                  state_in    = ST_MUL;
               end else begin
                  scale_x_in  = div_scale;
                  offset_x_in = div_low;
                  axis_in     = 1'b1;
                  state_in    = ST_DIVS;
               end
            end
         end
         ST_MUL: begin
            prod_in  = tpcm_pkg::PROD_W'(map_mag) * tpcm_pkg::PROD_W'(map_scale);
            neg_in   = map_diff[tpcm_pkg::RAW_W];
            state_in = ST_MAP;
         end
         ST_MAP: begin
            if (axis_ff) begin
               screen_y_in = map_sat;
               axis_in     = 1'b0;
               state_in    = ST_DONE;
            end else begin
               screen_x_in = map_sat;
               axis_in     = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = phase_rep;
               if (phase_rep == tpcm_pkg::PHASE_FIRST) begin
                  rsp_target_x_in = tpcm_pkg::TARGET_X0;
                  rsp_target_y_in = tpcm_pkg::TARGET_Y0;
                  rsp_screen_x_in = '0;
                  rsp_screen_y_in = '0;
               end else if (phase_rep == tpcm_pkg::PHASE_SECOND) begin
                  rsp_target_x_in = tpcm_pkg::TARGET_X1;
                  rsp_target_y_in = tpcm_pkg::TARGET_Y1;
                  rsp_screen_x_in = '0;
                  rsp_screen_y_in = '0;
               end else begin
                  rsp_target_x_in = '0;
                  rsp_target_y_in = '0;
                  rsp_screen_x_in = screen_x_ff;
                  rsp_screen_y_in = screen_y_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         axis_ff            <= 1'b0;
         cal_phase_ff       <= tpcm_pkg::PHASE_FIRST;
         first_x_ff         <= '0;
         first_y_ff         <= '0;
         last_change_ms_ff  <= '0;
         scale_x_ff         <= tpcm_pkg::SCALE_RESET;
         scale_y_ff         <= tpcm_pkg::SCALE_RESET;
         offset_x_ff        <= '0;
         offset_y_ff        <= '0;
         preset_scale_x_ff  <= tpcm_pkg::SCALE_RESET;
         preset_scale_y_ff  <= tpcm_pkg::SCALE_RESET;
         preset_offset_x_ff <= '0;
         preset_offset_y_ff <= '0;
         preset_valid_ff    <= 1'b0;
         hold_ms_ff         <= tpcm_pkg::HOLD_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         axis_ff            <= axis_in;
         cal_phase_ff       <= cal_phase_in;
         first_x_ff         <= first_x_in;
         first_y_ff         <= first_y_in;
         last_change_ms_ff  <= last_change_ms_in;
         scale_x_ff         <= scale_x_in;
         scale_y_ff         <= scale_y_in;
         offset_x_ff        <= offset_x_in;
         offset_y_ff        <= offset_y_in;
         preset_scale_x_ff  <= preset_scale_x_in;
         preset_scale_y_ff  <= preset_scale_y_in;
         preset_offset_x_ff <= preset_offset_x_in;
         preset_offset_y_ff <= preset_offset_y_in;
         preset_valid_ff    <= preset_valid_in;
         hold_ms_ff         <= hold_ms_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_x_ff        <= raw_x_in;
      raw_y_ff        <= raw_y_in;
      prod_ff         <= prod_in;
      neg_ff          <= neg_in;
      screen_x_ff     <= screen_x_in;
      screen_y_ff     <= screen_y_in;
      rsp_phase_ff    <= rsp_phase_in;
      rsp_target_x_ff <= rsp_target_x_in;
      rsp_target_y_ff <= rsp_target_y_in;
      rsp_screen_x_ff <= rsp_screen_x_in;
      rsp_screen_y_ff <= rsp_screen_y_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phase       = rsp_phase_ff;
   assign rsp_target_x    = rsp_target_x_ff;
   assign rsp_target_y    = rsp_target_y_ff;
   assign rsp_point_valid = (rsp_phase_ff == tpcm_pkg::PHASE_DONE);
   assign rsp_screen_x    = rsp_screen_x_ff;
   assign rsp_screen_y    = rsp_screen_y_ff;

endmodule
